// ===== hw/rtl/bmm_pkg.sv =====
// Shared definitions for the batched matrix multiply block: field widths,
// operation and register codes, reset values and the datapath control bundle.
// No dependencies.
package bmm_pkg;

   // Fixed field widths of the request, response and register channels.
   localparam int OP_W    = 2;
   localparam int BATCH_W = 2;
   localparam int IDX_W   = 3;
   localparam int ELEM_W  = 16;
   localparam int CVAL_W  = 32;
   localparam int DIM_W   = 4;
   localparam int NB_W    = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   // Operation codes carried in the op field.
   localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BATCHES = 2'd3;

   // Register values after reset.
   localparam logic [DIM_W-1:0] ROWS_RST    = 4'd8;
   localparam logic [DIM_W-1:0] INNER_RST   = 4'd8;
   localparam logic [DIM_W-1:0] COLS_RST    = 4'd8;
   localparam logic [NB_W-1:0]  BATCHES_RST = 3'd1;

   // Default sizes handed to the top level parameters.
   localparam int MAX_DIM_DEF    = 8;
   localparam int MAX_BATCH_DEF  = 4;
   localparam int ELEM_WIDTH_DEF = 16;

   // Control that travels with the store read data into the MAC datapath.
   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } mac_ctl_type;

endpackage

// ===== hw/rtl/bmm_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module bmm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bmm_mac.sv =====
// Multiply-accumulate datapath: registered product, accumulator and
// saturation of the final sum to 32 bits. Depends on bmm_pkg.
module bmm_mac #(
   parameter int EW = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bmm_pkg::mac_ctl_type       ctl,
   input  logic [EW-1:0]              a_data,
   input  logic [EW-1:0]              b_data,
   output logic [bmm_pkg::CVAL_W-1:0] sum,
   output logic                       done
);
   import bmm_pkg::*;

   localparam int PROD_W = 2 * EW;
   localparam int ACC_W  = (PROD_W + 4 > CVAL_W + 1) ? PROD_W + 4 : CVAL_W + 1;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     prod_vld_ff, prod_first_ff, prod_last_ff;
   logic [ACC_W-1:0]         acc_ff, acc_in, prod_ext;
   logic                     done_ff;
   logic [ACC_W-CVAL_W:0]    acc_hi;

   assign prod_in  = $signed(a_data) * $signed(b_data);
   assign prod_ext = {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign acc_in   = (prod_first_ff ? '0 : acc_ff) + prod_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         prod_vld_ff <= ctl.vld;
         done_ff     <= prod_vld_ff && prod_last_ff;
      end
      prod_ff       <= prod_in;
      prod_first_ff <= ctl.first;
      prod_last_ff  <= ctl.last;
      if (prod_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   // The sum is in range when every bit from bit 31 upward equals the sign.
   assign acc_hi = acc_ff[ACC_W-1:CVAL_W-1];

   always_comb begin
      if ((&acc_hi) || !(|acc_hi)) begin
         sum = acc_ff[CVAL_W-1:0];
      end else if (acc_ff[ACC_W-1]) begin
         sum = {1'b1, {(CVAL_W - 1){1'b0}}};
      end else begin
         sum = {1'b0, {(CVAL_W - 1){1'b1}}};
      end
   end

   assign done = done_ff;

endmodule

// ===== hw/rtl/batched_matrix_multiply.sv =====
// Batched matrix multiply, top level: request decode, sequencer, the A and B
// element stores and the response register. Depends on bmm_pkg, bmm_ram, bmm_mac.
//
// Usage. Requests arrive on the req_ channel (valid/stall). A load beat writes
// one element of A or B of one batch and produces no response; loads are taken
// one per cycle while idle with the response slot free. A compute beat for one
// batch streams every element of C = A * B in row-major order on the rsp_
// channel, the final beat flagged by rsp_last. A rejected request (bad op,
// batch or index) gives a single response with rsp_err and rsp_last set and a
// zero value. For each C element the inner loop reads one A and one B element
// per cycle through the single read port of each store, then the product and
// accumulator stages drain. The request channel is stalled for the whole
// compute. The csr_ port writes the four size registers; the user must write
// it only while idle, and the block itself does not enforce this. Reset returns
// the sequencer to idle, clears the response valid and sets the size registers
// to their reset values; the stores keep whatever they hold and must be loaded
// before use. When the receiver stalls, the response beat holds and the
// sequencer waits with the next finished element, so nothing is dropped.
module batched_matrix_multiply #(
   parameter int MAX_DIM    = bmm_pkg::MAX_DIM_DEF,
   parameter int MAX_BATCH  = bmm_pkg::MAX_BATCH_DEF,
   parameter int ELEM_WIDTH = bmm_pkg::ELEM_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel.
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [bmm_pkg::OP_W-1:0]       req_op,
   input  logic [bmm_pkg::BATCH_W-1:0]    req_batch,
   input  logic [bmm_pkg::IDX_W-1:0]      req_row,
   input  logic [bmm_pkg::IDX_W-1:0]      req_col,
   input  logic signed [bmm_pkg::ELEM_W-1:0] req_elem_value,
   // Response channel.
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [bmm_pkg::CVAL_W-1:0] rsp_c_value,
   output logic [bmm_pkg::IDX_W-1:0]      rsp_c_row,
   output logic [bmm_pkg::IDX_W-1:0]      rsp_c_col,
   output logic [bmm_pkg::BATCH_W-1:0]    rsp_c_batch,
   output logic                           rsp_err,
   output logic                           rsp_last,
   // Configuration write port.
   input  logic                           csr_wr_en,
   input  logic [bmm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bmm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bmm_pkg::*;

   // Only the low bits of an element up to 16 are kept in the stores.
   localparam int EW     = (ELEM_WIDTH < ELEM_W) ? ELEM_WIDTH : ELEM_W;
   localparam int DEPTH  = MAX_BATCH * MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NBC_W  = $clog2(MAX_BATCH + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   // Store address of element (r, c) of batch b, row-major within a batch.
   function automatic logic [ADDR_W-1:0] addr_of(logic [BATCH_W-1:0] b,
                                                 logic [IDX_W-1:0] r,
                                                 logic [IDX_W-1:0] c);
      return ADDR_W'((32'(b) * MAX_DIM + 32'(r)) * MAX_DIM + 32'(c));
   endfunction

   // Size registers are used saturated to 1..limit.
   function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
      if (v == '0) return DIM_W'(1);
      if (32'(v) > MAX_DIM) return DIM_W'(MAX_DIM);
      return v;
   endfunction

   function automatic logic [NBC_W-1:0] clamp_nb(logic [NB_W-1:0] v);
      if (v == '0) return NBC_W'(1);
      if (32'(v) > MAX_BATCH) return NBC_W'(MAX_BATCH);
      return NBC_W'(v);
   endfunction

   // Size registers.
   logic [DIM_W-1:0] rows_ff, inner_ff, cols_ff;
   logic [NB_W-1:0]  batches_ff;
   logic [DIM_W-1:0] n_rows, n_inner, n_cols;
   logic [NBC_W-1:0] n_batches;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff    <= ROWS_RST;
         inner_ff   <= INNER_RST;
         cols_ff    <= COLS_RST;
         batches_ff <= BATCHES_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ROWS:    rows_ff    <= csr_wdata;
            CSR_INNER:   inner_ff   <= csr_wdata;
            CSR_COLS:    cols_ff    <= csr_wdata;
            CSR_BATCHES: batches_ff <= csr_wdata[NB_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign n_rows    = clamp_dim(rows_ff);
   assign n_inner   = clamp_dim(inner_ff);
   assign n_cols    = clamp_dim(cols_ff);
   assign n_batches = clamp_nb(batches_ff);

   // Sequencer and response register.
   logic [1:0]          state_ff, state_in;
   logic [BATCH_W-1:0]  batch_ff, batch_in;
   logic [IDX_W-1:0]    i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CVAL_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [IDX_W-1:0]    rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [BATCH_W-1:0]  rsp_batch_ff, rsp_batch_in;
   logic                rsp_err_ff, rsp_err_in, rsp_last_ff, rsp_last_in;
   mac_ctl_type         rd_ctl_ff, rd_ctl_in;

   logic                out_free, req_take, bad;
   logic                k_end, i_end, j_end;
   logic                we_a, we_b;
   logic [ADDR_W-1:0]   wr_addr, rd_addr_a, rd_addr_b;
   logic [EW-1:0]       a_data, b_data;
   logic [CVAL_W-1:0]   mac_sum;
   logic                mac_done;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign req_take  = req_valid && !req_stall;

   // Request check against the current sizes.
   always_comb begin
      bad = (32'(req_batch) >= 32'(n_batches));
      case (req_op)
         OP_LOAD_A: begin
            if ({1'b0, req_row} >= n_rows || {1'b0, req_col} >= n_inner) bad = 1'b1;
         end
         OP_LOAD_B: begin
            if ({1'b0, req_row} >= n_inner || {1'b0, req_col} >= n_cols) bad = 1'b1;
         end
         OP_COMPUTE: begin
         end
         default: bad = 1'b1;
      endcase
   end

   assign we_a    = req_take && !bad && (req_op == OP_LOAD_A);
   assign we_b    = req_take && !bad && (req_op == OP_LOAD_B);
   assign wr_addr = addr_of(req_batch, req_row, req_col);

   // Read data is used only while running and writes happen only while idle, so
   // a write never meets a used read of a store entry in the same cycle.
   assign rd_addr_a = addr_of(batch_ff, i_ff, k_ff);
   assign rd_addr_b = addr_of(batch_ff, k_ff, j_ff);

   assign k_end = ({1'b0, k_ff} == n_inner - DIM_W'(1));
   assign j_end = ({1'b0, j_ff} == n_cols - DIM_W'(1));
   assign i_end = ({1'b0, i_ff} == n_rows - DIM_W'(1));

   always_comb begin
      state_in     = state_ff;
      batch_in     = batch_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_batch_in = rsp_batch_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;
      rd_ctl_in    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (bad) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = '0;
                  rsp_row_in   = req_row;
                  rsp_col_in   = req_col;
                  rsp_batch_in = req_batch;
                  rsp_err_in   = 1'b1;
                  rsp_last_in  = 1'b1;
               end else if (req_op == OP_COMPUTE) begin
                  batch_in = req_batch;
                  i_in     = '0;
                  j_in     = '0;
                  k_in     = '0;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            // One A and one B element per cycle for the current C element.
            rd_ctl_in.vld   = 1'b1;
            rd_ctl_in.first = (k_ff == '0);
            rd_ctl_in.last  = k_end;
            if (k_end) begin
               k_in     = '0;
               state_in = ST_WAIT;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         ST_WAIT: begin
            if (mac_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // The accumulator holds the sum until the response slot is free.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = mac_sum;
               rsp_row_in   = i_ff;
               rsp_col_in   = j_ff;
               rsp_batch_in = batch_ff;
               rsp_err_in   = 1'b0;
               rsp_last_in  = i_end && j_end;
               if (i_end && j_end) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_RUN;
                  if (j_end) begin
                     j_in = '0;
                     i_in = i_ff + IDX_W'(1);
                  end else begin
                     j_in = j_ff + IDX_W'(1);
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_ctl_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_ctl_ff    <= rd_ctl_in;
      end
      batch_ff     <= batch_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      rsp_value_ff <= rsp_value_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_batch_ff <= rsp_batch_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_last_ff  <= rsp_last_in;
   end

   bmm_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (we_a),
      .wr_addr (wr_addr),
      .wr_data (req_elem_value[EW-1:0]),
      .rd_addr (rd_addr_a),
      .rd_data (a_data)
   );

   bmm_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (we_b),
      .wr_addr (wr_addr),
      .wr_data (req_elem_value[EW-1:0]),
      .rd_addr (rd_addr_b),
      .rd_data (b_data)
   );

   bmm_mac #(
      .EW (EW)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (rd_ctl_ff),
      .a_data (a_data),
      .b_data (b_data),
      .sum    (mac_sum),
      .done   (mac_done)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_c_value = rsp_value_ff;
   assign rsp_c_row   = rsp_row_ff;
   assign rsp_c_col   = rsp_col_ff;
   assign rsp_c_batch = rsp_batch_ff;
   assign rsp_err     = rsp_err_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

// ===== hw/rtl/bmm_checker.sv =====
// Port-level checks for the batched matrix multiply block and the bind that
// attaches them to the top level. Depends on bmm_pkg and batched_matrix_multiply.
module bmm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [bmm_pkg::CVAL_W-1:0]        rsp_c_value,
   input logic                              rsp_err,
   input logic                              rsp_last
);
   import bmm_pkg::*;

   // No response beat is shown in the cycle after reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response beat holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_c_value))
      else $error("stalled response beat changed");

   // A rejected request gives exactly one beat, with a zero value.
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_err |-> rsp_last && (rsp_c_value == '0))
      else $error("error response not final or not zero");

   // While a compute still has elements to deliver, no request is taken.
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_err && !rsp_last |-> req_stall)
      else $error("request taken in the middle of a compute");

endmodule

bind batched_matrix_multiply bmm_checker u_bmm_checker (.*);

// ===== bench/batched_matrix_multiply_tb.sv =====
// Self-checking testbench for batched_matrix_multiply: directed table, then random
// load/compute jobs checked against a behavioral predictor of the A*B stores.
// Depends on bmm_pkg and the batched_matrix_multiply RTL.
module batched_matrix_multiply_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bmm_pkg::*;

   localparam int CLK_PERIOD    = 12;
   localparam int RESET_CYCLES  = 5;
   // Length of the receiver hold-off that forces the block to back up.
   localparam int HOLD_CYCLES   = 300;
   // Quiet cycles after the last response, enough for loads still in flight.
   localparam int SETTLE_CYCLES = 20;
   localparam int DIM_CAP       = MAX_DIM_DEF;
   localparam int BATCH_CAP     = MAX_BATCH_DEF;
   localparam logic [OP_W-1:0] OP_BAD = 2'd3;
   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;

   // One expected response beat.
   typedef struct {
      logic signed [CVAL_W-1:0] value;
      logic [IDX_W-1:0]         row;
      logic [IDX_W-1:0]         col;
      logic [BATCH_W-1:0]       batch;
      logic                     err;
      logic                     last;
   } c_elem_type;

   // One row of the directed table. Rows marked typed carry their single
   // expected beat inline; the others go through the predictor.
   typedef struct {
      logic [OP_W-1:0]    op;
      logic [BATCH_W-1:0] batch;
      logic [IDX_W-1:0]   row;
      logic [IDX_W-1:0]   col;
      logic [ELEM_W-1:0]  elem;
      bit                 typed;
      logic [CVAL_W-1:0]  exp_value;
      bit                 exp_err;
   } dir_row_type;

   // One random phase: register values (some deliberately outside 1..max),
   // idle percentages of sender and receiver, item budget and hold-off.
   typedef struct {
      logic [DIM_W-1:0] rows;
      logic [DIM_W-1:0] inner;
      logic [DIM_W-1:0] cols;
      logic [DIM_W-1:0] batches;
      int               send_idle;
      int               rcv_idle;
      int               budget;
      bit               hold;
   } phase_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [OP_W-1:0]          req_op = OP_LOAD_A;
   logic [BATCH_W-1:0]       req_batch = '0;
   logic [IDX_W-1:0]         req_row = '0;
   logic [IDX_W-1:0]         req_col = '0;
   logic signed [ELEM_W-1:0] req_elem_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [CVAL_W-1:0] rsp_c_value;
   logic [IDX_W-1:0]         rsp_c_row;
   logic [IDX_W-1:0]         rsp_c_col;
   logic [BATCH_W-1:0]       rsp_c_batch;
   logic                     rsp_err;
   logic                     rsp_last;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = CSR_ROWS;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   // Predictor state: its own copy of the size registers and both stores.
   // The seen flags track which store entries hold a loaded value, so that a
   // compute is only issued for a batch whose whole operand area is written.
   logic [DIM_W-1:0]  size_rows = ROWS_RST;
   logic [DIM_W-1:0]  size_inner = INNER_RST;
   logic [DIM_W-1:0]  size_cols = COLS_RST;
   logic [NB_W-1:0]   size_batches = BATCHES_RST;
   logic [ELEM_W-1:0] a_mem [BATCH_CAP*DIM_CAP*DIM_CAP];
   logic [ELEM_W-1:0] b_mem [BATCH_CAP*DIM_CAP*DIM_CAP];
   bit                a_seen [BATCH_CAP*DIM_CAP*DIM_CAP];
   bit                b_seen [BATCH_CAP*DIM_CAP*DIM_CAP];

   c_elem_type c_elems_due [$];
   int      mismatches = 0;
   int      beats_sent = 0;
   int      send_pct = 0;
   int      rcv_pct = 0;
   bit      hold_req = 1'b0;

   // Directed part, run with rows 1, inner 3, cols 1 and two batches.
   // Batch 0 is used for the two saturation cases: three products of the most
   // negative element give 3 * 2^30, which clips to the largest positive
   // value; swapping B to the largest positive element clips to the most
   // negative value. Then one rejected beat per rejection rule, and a batch 1
   // product of mixed extremes that the predictor works out.
   dir_row_type dir_tab [25] = '{
      '{OP_LOAD_A,  2'd0, 3'd0, 3'd0, 16'h8000, 1'b0, 32'h0,        1'b0},
      '{OP_LOAD_A,  2'd0, 3'd0, 3'd1, 16'h8000, 1'b0, 32'h0,        1'b0},
      '{OP_LOAD_A,  2'd0, 3'd0, 3'd2, 16'h8000, 1'b0, 32'h0,        1'b0},
      '{OP_LOAD_B,  2'd0, 3'd0, 3'd0, 16'h8000, 1'b0, 32'h0,        1'b0},
      '{OP_LOAD_B,  2'd0, 3'd1, 3'd0, 16'h8000, 1'b0, 32'h0,        1'b0},
      '{OP_LOAD_B,  2'd0, 3'd2, 3'd0, 16'h8000, 1'b0, 32'h0,        1'b0},
      '{OP_COMPUTE, 2'd0, 3'd0, 3'd0, 16'h0000, 1'b1, 32'h7fffffff, 1'b0},
      '{OP_LOAD_B,  2'd0, 3'd0, 3'd0, 16'h7fff, 1'b0, 32'h0,        1'b0},
      '{OP_LOAD_B,  2'd0, 3'd1, 3'd0, 16'h7fff, 1'b0, 32'h0,        1'b0},
      '{OP_LOAD_B,  2'd0, 3'd2, 3'd0, 16'h7fff, 1'b0, 32'h0,        1'b0},
      '{OP_COMPUTE, 2'd0, 3'd0, 3'd0, 16'hffff, 1'b1, 32'h80000000, 1'b0},
      '{OP_BAD,     2'd0, 3'd0, 3'd0, 16'hffff, 1'b1, 32'h0,        1'b1},
      '{OP_LOAD_A,  2'd2, 3'd0, 3'd0, 16'h1234, 1'b1, 32'h0,        1'b1},
      '{OP_LOAD_A,  2'd0, 3'd1, 3'd0, 16'h1234, 1'b1, 32'h0,        1'b1},
      '{OP_LOAD_A,  2'd0, 3'd0, 3'd3, 16'h1234, 1'b1, 32'h0,        1'b1},
      '{OP_LOAD_B,  2'd1, 3'd3, 3'd0, 16'h1234, 1'b1, 32'h0,        1'b1},
      '{OP_LOAD_B,  2'd1, 3'd0, 3'd1, 16'h1234, 1'b1, 32'h0,        1'b1},
      '{OP_COMPUTE, 2'd3, 3'd7, 3'd7, 16'h8000, 1'b1, 32'h0,        1'b1},
      '{OP_LOAD_A,  2'd1, 3'd0, 3'd0, 16'h7fff, 1'b0, 32'h0,        1'b0},
      '{OP_LOAD_A,  2'd1, 3'd0, 3'd1, 16'hffff, 1'b0, 32'h0,        1'b0},
      '{OP_LOAD_A,  2'd1, 3'd0, 3'd2, 16'h0001, 1'b0, 32'h0,        1'b0},
      '{OP_LOAD_B,  2'd1, 3'd0, 3'd0, 16'h7fff, 1'b0, 32'h0,        1'b0},
      '{OP_LOAD_B,  2'd1, 3'd1, 3'd0, 16'h8000, 1'b0, 32'h0,        1'b0},
      '{OP_LOAD_B,  2'd1, 3'd2, 3'd0, 16'hffff, 1'b0, 32'h0,        1'b0},
      '{OP_COMPUTE, 2'd1, 3'd6, 3'd5, 16'h5a5a, 1'b0, 32'h0,        1'b0}
   };

   // Random phases. The first two have the sender idle about a third of the
   // time and the receiver about two thirds, the next three the other way
   // round, the last three run without idling. Register values of 0 and
   // above the maximum check that the block clamps them. Only one phase uses
   // the full 8x8x8 size, since its loads alone take 128 beats.
   phase_type phase_tab [8] = '{
      '{4'd2,  4'd2, 4'd2,  4'd4, 34, 63, 20,  1'b0},
      '{4'd3,  4'd1, 4'd4,  4'd3, 34, 63, 20,  1'b1},
      '{4'd1,  4'd4, 4'd1,  4'd2, 63, 34, 20,  1'b0},
      '{4'd15, 4'd0, 4'd0,  4'd7, 63, 34, 20,  1'b0},
      '{4'd0,  4'd1, 4'd15, 4'd0, 63, 34, 20,  1'b0},
      '{4'd8,  4'd8, 4'd8,  4'd1, 0,  0,  100, 1'b0},
      '{4'd1,  4'd1, 4'd1,  4'd4, 0,  0,  20,  1'b0},
      '{4'd4,  4'd3, 4'd2,  4'd2, 0,  0,  20,  1'b0}
   };

   batched_matrix_multiply dut (.*);

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Hard stop in case the block hangs or a response never shows up.
   initial begin
      #40ms;
      $display("batched_matrix_multiply_tb failed");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // Register values are used clamped into the legal range.
   function automatic int clamp_dim(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int eff_rows();
      return clamp_dim(size_rows, DIM_CAP);
   endfunction

   function automatic int eff_inner();
      return clamp_dim(size_inner, DIM_CAP);
   endfunction

   function automatic int eff_cols();
      return clamp_dim(size_cols, DIM_CAP);
   endfunction

   function automatic int eff_batches();
      return clamp_dim(size_batches, BATCH_CAP);
   endfunction

   function automatic int store_addr(int b, int r, int c);
      return (b * DIM_CAP + r) * DIM_CAP + c;
   endfunction

   // True when every A and B entry that a compute of this batch reads has
   // been loaded at some point (the stores survive size changes).
   function automatic bit batch_ready(int b);
      for (int i = 0; i < eff_rows(); i++)
         for (int k = 0; k < eff_inner(); k++)
            if (!a_seen[store_addr(b, i, k)]) return 1'b0;
      for (int k = 0; k < eff_inner(); k++)
         for (int j = 0; j < eff_cols(); j++)
            if (!b_seen[store_addr(b, k, j)]) return 1'b0;
      return 1'b1;
   endfunction

   // Applies one accepted request to the predictor state and queues the
   // response beats it must produce.
   task automatic predict_c_elems(input logic [OP_W-1:0] op, input logic [BATCH_W-1:0] batch,
                                  input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                                  input logic [ELEM_W-1:0] elem);
      int      nr;
      int      nk;
      int      nc;
      bit      bad;
      longint  acc;
      c_elem_type e;
      nr = eff_rows();
      nk = eff_inner();
      nc = eff_cols();
      bad = (op == OP_BAD) || (batch >= eff_batches());
      if (!bad && op == OP_LOAD_A && (row >= nr || col >= nk)) bad = 1'b1;
      if (!bad && op == OP_LOAD_B && (row >= nk || col >= nc)) bad = 1'b1;
      if (bad) begin
         // Rejected: one beat, zero value, position and batch echoed.
         c_elems_due.push_back(c_elem_type'{'0, row, col, batch, 1'b1, 1'b1});
      end else if (op == OP_LOAD_A) begin
         a_mem[store_addr(batch, row, col)] = elem;
         a_seen[store_addr(batch, row, col)] = 1'b1;
      end else if (op == OP_LOAD_B) begin
         b_mem[store_addr(batch, row, col)] = elem;
         b_seen[store_addr(batch, row, col)] = 1'b1;
      end else begin
         // Exact sum of signed Q15.0 element products, clipped to 32 bits only at the end.
         for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
               acc = 0;
               for (int k = 0; k < nk; k++)
                  acc += longint'($signed(a_mem[store_addr(batch, i, k)])) *
                         longint'($signed(b_mem[store_addr(batch, k, j)]));
               if (acc > SAT_HI) acc = SAT_HI;
               if (acc < SAT_LO) acc = SAT_LO;
               e.value = acc[CVAL_W-1:0];
               e.row = i[IDX_W-1:0];
               e.col = j[IDX_W-1:0];
               e.batch = batch;
               e.err = 1'b0;
               e.last = (i == nr - 1) && (j == nc - 1);
               c_elems_due.push_back(e);
            end
         end
      end
   endtask

   // Offers one request beat and returns on the clock edge that accepts it.
   // Before the beat, each cycle is left idle with the sender's idle
   // percentage. Valid is only lowered in such an idle cycle.
   task automatic send_beat(input logic [OP_W-1:0] op, input logic [BATCH_W-1:0] batch,
                            input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                            input logic [ELEM_W-1:0] elem);
      while ($urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_batch <= batch;
      req_row <= row;
      req_col <= col;
      req_elem_value <= elem;
      do @(posedge clock); while (req_stall);
      beats_sent++;
   endtask

   task automatic issue_item(input logic [OP_W-1:0] op, input logic [BATCH_W-1:0] batch,
                             input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                             input logic [ELEM_W-1:0] elem);
      send_beat(op, batch, row, col, elem);
      predict_c_elems(op, batch, row, col, elem);
   endtask

   // Element values lean on the two extremes so that large sums turn up.
   function automatic logic [ELEM_W-1:0] rand_elem();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7fff;
         default: return 16'($urandom);
      endcase
   endfunction

   // Writes all four size registers in consecutive cycles, with the write
   // enable held high throughout and dropped once at the end.
   task automatic write_sizes(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] k,
                              input logic [DIM_W-1:0] c, input logic [DIM_W-1:0] nb);
      logic [CSR_IDX_W-1:0]  regs [4];
      logic [CSR_DATA_W-1:0] vals [4];
      regs = '{CSR_ROWS, CSR_INNER, CSR_COLS, CSR_BATCHES};
      vals = '{r, k, c, nb};
      for (int n = 0; n < 4; n++) begin
         csr_wr_en <= 1'b1;
         csr_index <= regs[n];
         csr_wdata <= vals[n];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      size_rows = r;
      size_inner = k;
      size_cols = c;
      size_batches = nb[NB_W-1:0];
   endtask

   // Brings the block to idle: no request offered, every expected beat in,
   // then a quiet wait for loads that produce no beat.
   task automatic drain_idle();
      req_valid <= 1'b0;
      while (c_elems_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // A broken or stray beat: bad op, batch out of range, load index out of
   // range, or fully random fields. A random compute on a batch that is not
   // fully loaded would read unwritten entries, so it becomes a bad op.
   task automatic send_noise();
      int                 nr;
      int                 nk;
      int                 nc;
      int                 nb;
      logic [OP_W-1:0]    op;
      logic [BATCH_W-1:0] b;
      logic [IDX_W-1:0]   r;
      logic [IDX_W-1:0]   c;
      nr = eff_rows();
      nk = eff_inner();
      nc = eff_cols();
      nb = eff_batches();
      op = OP_W'($urandom);
      b = BATCH_W'($urandom);
      r = IDX_W'($urandom);
      c = IDX_W'($urandom);
      case ($urandom_range(4))
         0: op = OP_BAD;
         1: begin
            if (nb < BATCH_CAP) b = BATCH_W'($urandom_range(BATCH_CAP - 1, nb));
            else op = OP_BAD;
         end
         2: begin
            op = OP_LOAD_A;
            b = BATCH_W'($urandom_range(nb - 1));
            if (nr < DIM_CAP) r = IDX_W'($urandom_range(DIM_CAP - 1, nr));
            else if (nk < DIM_CAP) c = IDX_W'($urandom_range(DIM_CAP - 1, nk));
            else op = OP_BAD;
         end
         3: begin
            op = OP_LOAD_B;
            b = BATCH_W'($urandom_range(nb - 1));
            if (nk < DIM_CAP) r = IDX_W'($urandom_range(DIM_CAP - 1, nk));
            else if (nc < DIM_CAP) c = IDX_W'($urandom_range(DIM_CAP - 1, nc));
            else op = OP_BAD;
         end
         default: ;
      endcase
      if (op == OP_COMPUTE && b < nb && !batch_ready(b)) op = OP_BAD;
      issue_item(op, b, r, c, rand_elem());
   endtask

   // A well-formed job: load the operands of one batch, then compute it.
   // A batch that is already complete is sometimes only partly reloaded, and
   // now and then a stray beat is slipped in before the compute.
   task automatic run_job();
      int b;
      bit full;
      b = $urandom_range(eff_batches() - 1);
      full = !batch_ready(b) || ($urandom_range(3) == 0);
      for (int i = 0; i < eff_rows(); i++)
         for (int k = 0; k < eff_inner(); k++)
            if (full || $urandom_range(3) == 0)
               issue_item(OP_LOAD_A, BATCH_W'(b), IDX_W'(i), IDX_W'(k), rand_elem());
      for (int k = 0; k < eff_inner(); k++)
         for (int j = 0; j < eff_cols(); j++)
            if (full || $urandom_range(3) == 0)
               issue_item(OP_LOAD_B, BATCH_W'(b), IDX_W'(k), IDX_W'(j), rand_elem());
      if ($urandom_range(5) == 0) send_noise();
      issue_item(OP_COMPUTE, BATCH_W'(b), IDX_W'($urandom), IDX_W'($urandom), rand_elem());
   endtask

   // Receiver: stalls at the phase's rate. When a hold-off is requested it
   // keeps stall high for the whole hold-off, so that a compute backs up into
   // the block while the sender keeps offering beats.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < rcv_pct);
         end
      end
   end

   // Response checker: each accepted beat is compared field by field with
   // the oldest expected beat.
   always @(posedge clock) begin
      c_elem_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (c_elems_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected beat batch %0d row %0d col %0d value %h",
                                    rsp_c_batch, rsp_c_row, rsp_c_col, rsp_c_value));
         end else begin
            want = c_elems_due.pop_front();
            if (rsp_c_value !== want.value)
               flag_mismatch($sformatf("c_value %h, want %h (batch %0d row %0d col %0d)",
                                       rsp_c_value, want.value, want.batch, want.row,
                                       want.col));
            if (rsp_c_row !== want.row)
               flag_mismatch($sformatf("c_row %0d, want %0d", rsp_c_row, want.row));
            if (rsp_c_col !== want.col)
               flag_mismatch($sformatf("c_col %0d, want %0d", rsp_c_col, want.col));
            if (rsp_c_batch !== want.batch)
               flag_mismatch($sformatf("c_batch %0d, want %0d", rsp_c_batch, want.batch));
            if (rsp_err !== want.err)
               flag_mismatch($sformatf("err %b, want %b (batch %0d row %0d col %0d)",
                                       rsp_err, want.err, want.batch, want.row, want.col));
            if (rsp_last !== want.last)
               flag_mismatch($sformatf("last %b, want %b (batch %0d row %0d col %0d)",
                                       rsp_last, want.last, want.batch, want.row, want.col));
         end
      end
   end

   // Main sequence: reset, directed table, random phases, final verdict.
   initial begin
      int phase_start;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      send_pct = 34;
      rcv_pct = 63;
      write_sizes(4'd1, 4'd3, 4'd1, 4'd2);
      foreach (dir_tab[n]) begin
         send_beat(dir_tab[n].op, dir_tab[n].batch, dir_tab[n].row, dir_tab[n].col,
                   dir_tab[n].elem);
         if (dir_tab[n].typed)
            c_elems_due.push_back(c_elem_type'{dir_tab[n].exp_value, dir_tab[n].row,
                                               dir_tab[n].col, dir_tab[n].batch,
                                               dir_tab[n].exp_err, 1'b1});
         else
            predict_c_elems(dir_tab[n].op, dir_tab[n].batch, dir_tab[n].row,
                            dir_tab[n].col, dir_tab[n].elem);
      end

      // Sizes only change while the block is idle.
      foreach (phase_tab[p]) begin
         drain_idle();
         write_sizes(phase_tab[p].rows, phase_tab[p].inner, phase_tab[p].cols,
                     phase_tab[p].batches);
         send_pct = phase_tab[p].send_idle;
         rcv_pct = phase_tab[p].rcv_idle;
         if (phase_tab[p].hold) hold_req = 1'b1;
         phase_start = beats_sent;
         while (beats_sent - phase_start < phase_tab[p].budget) begin
            if ($urandom_range(99) < 15) send_noise();
            else run_job();
         end
      end

      drain_idle();
      if (mismatches == 0) begin
         $display("batched_matrix_multiply_tb passed");
      end else begin
         $display("batched_matrix_multiply_tb failed");
      end
      $finish;
   end

endmodule
